[rtl/lpef_pkg.sv]
// ----------------------------------------------------------------------------
// lpef_pkg
// Shared widths, codes and types of the prediction-error FIR.
// ----------------------------------------------------------------------------
package lpef_pkg;

  localparam int MAX_ORDER = 20;

  localparam int SMP_W  = 24;  // input sample
  localparam int COEF_W = 20;  // Q4.15 coefficient
  localparam int OUT_W  = 26;  // saturated result
  localparam int ORD_W  = 5;   // filter_order register
  localparam int IDX_W  = 5;   // coef_index field
  localparam int FRAC_W = 15;

  localparam int PROD_W    = SMP_W + COEF_W;
  // leaf 0 carries the sample term, leaves 1..MAX_ORDER the tap products
  localparam int TREE_LVLS = $clog2(MAX_ORDER + 1);
  localparam int TREE_N    = 1 << TREE_LVLS;
  localparam int ACC_W     = PROD_W + TREE_LVLS + 1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_FILTER = 1'b1
  } op_e;

  typedef struct packed {
    logic push;   // sample accepted: capture product, shift history
    logic clear;  // band start with that sample
  } cell_ctrl_t;

endpackage

[rtl/lpef_if.sv]
// ----------------------------------------------------------------------------
// lpef_in_if / lpef_out_if
// Valid/ready channels for sample or coefficient items and for results.
// ----------------------------------------------------------------------------
interface lpef_in_if import lpef_pkg::*; ();
  logic                      valid;
  logic                      ready;
  op_e                       op;
  logic        [IDX_W-1:0]   coef_index;
  logic signed [COEF_W-1:0]  coef_value;
  logic signed [SMP_W-1:0]   sample;
  logic                      band_start;

  modport source (output valid, op, coef_index, coef_value, sample, band_start,
                  input ready);
  modport sink   (input valid, op, coef_index, coef_value, sample, band_start,
                  output ready);
endinterface

interface lpef_out_if import lpef_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

[rtl/lpef_tap_cell.sv]
// ----------------------------------------------------------------------------
// lpef_tap_cell
// One tap: a history sample, its coefficient and the registered product.
// ----------------------------------------------------------------------------
module lpef_tap_cell import lpef_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic                      tap_on_i,
  input  logic                      coef_we_i,
  input  logic signed [COEF_W-1:0]  coef_i,
  input  logic signed [SMP_W-1:0]   hist_i,
  output logic signed [SMP_W-1:0]   hist_o,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [SMP_W-1:0]  hist_q;
  logic signed [COEF_W-1:0] coef_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;

  // a band start empties the history before this sample's products
  assign hist_o = ctrl_i.clear ? '0 : hist_q;

  always_comb begin
    prod_d = coef_q * hist_q;
    if (ctrl_i.clear || !tap_on_i) begin
      prod_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      coef_q <= '0;
    end else begin
      if (ctrl_i.push) begin
        hist_q <= hist_i;
      end
      if (coef_we_i) begin
        coef_q <= coef_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/lpef_adder_tree.sv]
// ----------------------------------------------------------------------------
// lpef_adder_tree
// Registered binary adder tree, one level per stage, with per-level stall.
// ----------------------------------------------------------------------------
module lpef_adder_tree import lpef_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [ACC_W-1:0]  leaf_i [TREE_N],
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ACC_W-1:0]  sum_o
);

  // heap order: node 1 is the root, children of i are 2i and 2i+1
  logic signed [ACC_W-1:0] node_q [1:TREE_N-1];
  logic [TREE_LVLS-1:0]    lvl_v_q;
  logic [TREE_LVLS-1:0]    lvl_en;

  always_comb begin
    lvl_en[0] = !lvl_v_q[0] || out_ready_i;
    for (int d = 1; d < TREE_LVLS; d++) begin
      lvl_en[d] = !lvl_v_q[d] || lvl_en[d-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_v_q <= '0;
    end else begin
      for (int d = 0; d < TREE_LVLS - 1; d++) begin
        if (lvl_en[d]) begin
          lvl_v_q[d] <= lvl_v_q[d+1];
        end
      end
      if (lvl_en[TREE_LVLS-1]) begin
        lvl_v_q[TREE_LVLS-1] <= in_valid_i;
      end
    end
  end

  for (genvar i = 1; i < TREE_N; i++) begin : g_node
    localparam int D = $clog2(i + 1) - 1;
    if (2 * i >= TREE_N) begin : g_leaf
      always_ff @(posedge clk_i) begin
        if (lvl_en[D]) begin
          node_q[i] <= leaf_i[2*i-TREE_N] + leaf_i[2*i+1-TREE_N];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        if (lvl_en[D]) begin
          node_q[i] <= node_q[2*i] + node_q[2*i+1];
        end
      end
    end
  end

  assign in_ready_o  = lvl_en[TREE_LVLS-1];
  assign out_valid_o = lvl_v_q[0];
  assign sum_o       = node_q[1];

endmodule

[rtl/lpc_prediction_error_filter.sv]
// ----------------------------------------------------------------------------
// lpc_prediction_error_filter
// TNS analysis FIR: sample plus weighted sum of previous samples, saturated.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries op/coef_index/coef_value/sample/band_start. An op=LOAD
//   item writes one coefficient into its tap cell at acceptance; indexes
//   outside 1..MAX_ORDER are dropped. An op=FILTER item gives exactly one
//   result on result_o; loads give none.
//   cfg_we_i/cfg_wdata_i write filter_order (taps in use), only while idle.
//   Throughput: one item per cycle while result_o keeps taking results,
//   set by the row of tap cells which each multiply once per accepted
//   sample and shift their history sample on.
//   Pipeline: the product stage loads at the accept edge, then one stage
//   per adder-tree level (21 terms), then the round/saturate output register.
//   Stalls: every stage has its own valid bit and moves when the stage
//   after it frees up, so the pipe fills completely behind a stalled
//   result before item_i.ready drops.
//   Reset: history, coefficients and filter_order go to zero, pipe empty.
// ----------------------------------------------------------------------------
module lpc_prediction_error_filter import lpef_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ORD_W-1:0]  cfg_wdata_i,
  lpef_in_if.sink           item_i,
  lpef_out_if.source        result_o
);

  localparam int Y_W = ACC_W - FRAC_W;
  localparam logic signed [Y_W-1:0] Y_MAX =
    {{(Y_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN =
    {{(Y_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic [ORD_W-1:0] order_q;

  logic       in_acc, smp_acc, load_acc;
  cell_ctrl_t ctrl;

  logic                     cell_v_q;
  logic signed [ACC_W-1:0]  xterm_d, xterm_q;
  logic signed [SMP_W-1:0]  hist_w [MAX_ORDER];
  logic signed [PROD_W-1:0] prod_w [MAX_ORDER];
  logic signed [ACC_W-1:0]  leaf   [TREE_N];

  logic                     tree_ready, tree_v;
  logic signed [ACC_W-1:0]  tree_sum;

  logic                     res_en;
  logic                     res_v_q;
  logic signed [OUT_W-1:0]  res_d, res_q;
  logic signed [Y_W-1:0]    y;

  // ---- input side ----
  // product stage takes a new sample when empty or when the tree moves on
  assign item_i.ready = !cell_v_q || tree_ready;
  assign in_acc       = item_i.valid && item_i.ready;
  assign smp_acc      = in_acc && (item_i.op == OP_FILTER);
  assign load_acc     = in_acc && (item_i.op == OP_LOAD);

  assign ctrl.push  = smp_acc;
  assign ctrl.clear = smp_acc && item_i.band_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // sample term x*2^15 with the rounding half (2^14) folded in
  assign xterm_d = $signed({{(ACC_W-SMP_W-FRAC_W){item_i.sample[SMP_W-1]}},
                            item_i.sample, 1'b1, {(FRAC_W-1){1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_v_q <= 1'b0;
    end else if (item_i.ready) begin
      cell_v_q <= smp_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      xterm_q <= xterm_d;
    end
  end

  // ---- row of tap cells; cell k holds history[k] and a[k+1] ----
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
    logic signed [SMP_W-1:0] hist_in;
    logic                    tap_on, coef_we;

    if (k == 0) begin : g_head
      assign hist_in = item_i.sample;
    end else begin : g_body
      assign hist_in = hist_w[k-1];
    end

    // order above the row length still enables every tap
    assign tap_on  = ORD_W'(k) < order_q;
    assign coef_we = load_acc && ({1'b0, item_i.coef_index} == (IDX_W+1)'(k + 1));

    lpef_tap_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .tap_on_i  (tap_on),
      .coef_we_i (coef_we),
      .coef_i    (item_i.coef_value),
      .hist_i    (hist_in),
      .hist_o    (hist_w[k]),
      .prod_o    (prod_w[k])
    );
  end

  always_comb begin
    for (int n = 0; n < TREE_N; n++) begin
      leaf[n] = '0;
    end
    leaf[0] = xterm_q;
    for (int k = 0; k < MAX_ORDER; k++) begin
      leaf[k+1] = ACC_W'(prod_w[k]);
    end
  end

  // ---- summation ----
  lpef_adder_tree u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .leaf_i      (leaf),
    .in_valid_i  (cell_v_q),
    .in_ready_o  (tree_ready),
    .out_valid_o (tree_v),
    .out_ready_i (res_en),
    .sum_o       (tree_sum)
  );

  // ---- round (floor after +2^14) and saturate ----
  assign y = tree_sum[ACC_W-1:FRAC_W];

  always_comb begin
    if (y > Y_MAX) begin
      res_d = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (y < Y_MIN) begin
      res_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res_d = y[OUT_W-1:0];
    end
  end

  assign res_en = !res_v_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (res_en) begin
      res_v_q <= tree_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_en) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid    = res_v_q;
  assign result_o.filtered = res_q;

  // ---- checks ----
  // input can only back up when the result side is holding an item
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> (result_o.valid && !result_o.ready))
    else $error("input stalled without output back-pressure");

  // a coefficient load never occupies the product stage
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> !cell_v_q)
    else $error("coefficient load entered the pipe");

  // an accepted sample lands in the first history tap
  a_head_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> (ctrl.clear || hist_w[0] == $past(item_i.sample)))
    else $error("first tap does not hold the last sample");

  // a sample in the product stage is held while the tree is stalled
  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_v_q && !tree_ready) |=> (cell_v_q && $stable(xterm_q)))
    else $error("product stage lost an item under stall");

endmodule

[test/lpc_prediction_error_filter_test.sv]
// ----------------------------------------------------------------------------
// lpc_prediction_error_filter_test
// Self-checking bench for the prediction-error FIR. A scoreboard class keeps
// its own copy of history, taps and filter order, and predicts every filtered
// output. Directed items hit field extremes, saturation and ignored loads.
// Random bands of samples with coefficient reloads and random idling on both
// channels follow.
// ----------------------------------------------------------------------------
import lpef_pkg::*;

typedef struct packed {
  op_e                       op;
  logic        [IDX_W-1:0]   coef_index;
  logic signed [COEF_W-1:0]  coef_value;
  logic signed [SMP_W-1:0]   sample;
  logic                      band_start;
} fir_item_t;

class whitening_scoreboard;
  localparam longint ERR_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint ERR_MIN = -(longint'(1) <<< (OUT_W - 1));

  logic signed [SMP_W-1:0]  past_samples [MAX_ORDER];
  logic signed [COEF_W-1:0] taps [MAX_ORDER];
  logic        [ORD_W-1:0]  order;
  logic signed [OUT_W-1:0]  expected_errors [$];
  int mismatches, samples, loads, clipped, outputs;

  function new();
    foreach (past_samples[j]) past_samples[j] = '0;
    foreach (taps[j]) taps[j] = '0;
    order = '0;
  endfunction

  function int pending();
    return expected_errors.size();
  endfunction

  // sample plus weighted sum of past samples, rounded half up, clipped
  function logic signed [OUT_W-1:0] predict_error(logic signed [SMP_W-1:0] x);
    longint acc;
    int     used;
    used = (order > MAX_ORDER) ? MAX_ORDER : int'(order);
    acc  = longint'(x) <<< FRAC_W;
    for (int j = 0; j < used; j++)
      acc += longint'(taps[j]) * longint'(past_samples[j]);
    acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    if (acc > ERR_MAX) begin
      acc = ERR_MAX;
      clipped++;
    end else if (acc < ERR_MIN) begin
      acc = ERR_MIN;
      clipped++;
    end
    return OUT_W'(acc);
  endfunction

  function void note_item(fir_item_t it);
    if (it.op == OP_LOAD) begin
      if (it.coef_index >= 1 && it.coef_index <= MAX_ORDER)
        taps[it.coef_index - 1] = it.coef_value;
      loads++;
      return;
    end
    if (it.band_start)
      foreach (past_samples[j]) past_samples[j] = '0;
    expected_errors.push_back(predict_error(it.sample));
    for (int j = MAX_ORDER - 1; j > 0; j--) past_samples[j] = past_samples[j - 1];
    past_samples[0] = it.sample;
    samples++;
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(logic signed [OUT_W-1:0] got);
    logic signed [OUT_W-1:0] want;
    outputs++;
    if (expected_errors.size() == 0) begin
      report_mismatch($sformatf("output %0d (%0d) with nothing expected", outputs, got));
      return;
    end
    want = expected_errors.pop_front();
    if (got !== want)
      report_mismatch($sformatf("output %0d: filtered %0d, expected %0d", outputs, got, want));
  endtask
endclass

module lpc_prediction_error_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  // accept-to-result latency of the pipe stages, plus margin
  localparam int LATENCY     = TREE_LVLS + 1;
  localparam int SETTLE      = LATENCY + 8;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 100;     // about 900 random items overall
  localparam int TIMEOUT_NS  = 2_000_000;

  localparam logic signed [SMP_W-1:0]  SMP_MAX  = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0]  SMP_MIN  = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ORD_W-1:0] cfg_wdata_i;

  lpef_in_if  item_if ();
  lpef_out_if result_if ();

  lpc_prediction_error_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  whitening_scoreboard sb;

  // Idle controls shared between the stimulus and the result sink.
  // *_calm turns off the random gaps for a stretch; hold_req asks the sink
  // for one long stall so the pipe backs up into item_i.ready.
  bit tx_calm, rx_calm, hold_req;
  int order_writes;

  always #2 clk_i = ~clk_i;

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timed out with %0d outputs still expected", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: a random stall before each output, or the one long hold
  // when asked. Outputs are sampled at the edge where they are taken,
  // before that edge's updates land.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    result_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
      sb.check_result(result_if.filtered);
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Valid stays up after a take; it only drops when a gap is drawn or the
  // stream pauses, so back-to-back items never toggle it within one step.
  task automatic send_item(fir_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.op         <= it.op;
    item_if.coef_index <= it.coef_index;
    item_if.coef_value <= it.coef_value;
    item_if.sample     <= it.sample;
    item_if.band_start <= it.band_start;
    do @(posedge clk_i); while (!item_if.ready);
    sb.note_item(it);
  endtask

  // Loads give no output, so after the last expected output we still wait
  // out the pipe before touching the order register.
  task automatic drain();
    item_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_order(logic [ORD_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.order = v;
    order_writes++;
  endtask

  // Load items carry junk in the sample fields, which the block must ignore.
  function automatic fir_item_t load_item(int idx, logic signed [COEF_W-1:0] a);
    fir_item_t it;
    it.op         = OP_LOAD;
    it.coef_index = IDX_W'(idx);
    it.coef_value = a;
    it.sample     = SMP_W'($urandom);
    it.band_start = 1'($urandom);
    return it;
  endfunction

  // ...and sample items junk in the coefficient fields.
  function automatic fir_item_t sample_item(logic signed [SMP_W-1:0] x, bit start);
    fir_item_t it;
    it.op         = OP_FILTER;
    it.coef_index = IDX_W'($urandom);
    it.coef_value = COEF_W'($urandom);
    it.sample     = x;
    it.band_start = start;
    return it;
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return SMP_W'(int'($urandom_range(0, 511)) - 256);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // mostly realistic predictor taps (-1 <= a < 1), some extremes and full range
  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2, 3, 4: return COEF_W'(int'($urandom_range(0, 65535)) - 32768);
      5:       return COEF_W'(int'($urandom_range(0, 127)) - 64);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  phase_items, band_len, taps_used, n, idx;
    bit  start, first_band, full_reload;
    logic [ORD_W-1:0] ord;

    sb = new();
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_wdata_i           <= '0;
    item_if.valid         <= 1'b0;
    item_if.op            <= OP_FILTER;
    item_if.coef_index    <= '0;
    item_if.coef_value    <= '0;
    item_if.sample        <= '0;
    item_if.band_start    <= 1'b0;
    tx_calm  = 1'b0;
    rx_calm  = 1'b0;
    hold_req = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Order zero out of reset: output equals the sample, extremes included.
    send_item(sample_item(SMP_MAX, 1'b1));
    send_item(sample_item(SMP_MIN, 1'b0));

    // Extreme taps, plus loads to tap 0 and taps beyond the maximum order,
    // which must leave the store untouched.
    send_item(load_item(1, COEF_MAX));
    send_item(load_item(2, COEF_MAX));
    send_item(load_item(3, COEF_MIN));
    send_item(load_item(MAX_ORDER, COEF_MIN));
    send_item(load_item(0, COEF_W'(12345)));
    send_item(load_item(MAX_ORDER + 1, COEF_MAX));
    send_item(load_item((1 << IDX_W) - 1, COEF_MIN));

    // Three taps of full-scale weight drive the sum into both clip limits.
    drain();
    write_order(ORD_W'(3));
    send_item(sample_item(SMP_MAX, 1'b1));
    send_item(sample_item(SMP_MAX, 1'b0));
    send_item(sample_item(SMP_MAX, 1'b0));
    send_item(sample_item(SMP_MIN, 1'b0));
    send_item(sample_item(SMP_MIN, 1'b0));
    send_item(sample_item(SMP_MIN, 1'b0));
    send_item(sample_item('0, 1'b1));

    // Order above the maximum is used as the maximum; the band carries on
    // without a band start, and a tap reload mid-band hits the next sample.
    drain();
    write_order('1);
    send_item(sample_item(SMP_MIN, 1'b0));
    send_item(sample_item(SMP_W'(-1), 1'b0));
    send_item(load_item(2, COEF_W'(-1)));
    send_item(sample_item(SMP_W'(1), 1'b0));

    drain();
    write_order(ORD_W'(MAX_ORDER));
    send_item(sample_item(pick_sample(), 1'b0));
    send_item(sample_item(pick_sample(), 1'b0));

    drain();
    write_order('0);
    send_item(sample_item(SMP_MAX, 1'b0));

    // Random phases: each phase runs at one filter order, extremes first.
    // Within it, bands look like the real use: reload some or all taps, then
    // a run of samples opened by a band start, with the odd stray load,
    // out-of-range tap number or extra band start thrown in.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       ord = ORD_W'(MAX_ORDER);
        1:       ord = '0;
        2:       ord = '1;
        3:       ord = ORD_W'(1);
        default: ord = ORD_W'($urandom_range(0, (1 << ORD_W) - 1));
      endcase
      drain();
      write_order(ord);
      // one phase with the sink held off while the source pushes flat out
      if (phase == 4) hold_req = 1'b1;
      phase_items = 0;
      first_band  = 1'b1;
      while (phase_items < PHASE_ITEMS) begin
        tx_calm   = (phase == 4) || ($urandom_range(0, 3) == 0);
        rx_calm   = ($urandom_range(0, 3) == 0);
        taps_used = (sb.order > MAX_ORDER) ? MAX_ORDER : int'(sb.order);
        full_reload = ($urandom_range(0, 2) == 0);
        n = full_reload ? taps_used : $urandom_range(0, 3);
        for (int t = 1; t <= n; t++) begin
          idx = full_reload ? t : $urandom_range(1, MAX_ORDER);
          send_item(load_item(idx, pick_coef()));
          phase_items++;
        end
        band_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                               : $urandom_range(1, 24);
        for (int i = 0; i < band_len; i++) begin
          if ($urandom_range(0, 24) == 0) begin
            if ($urandom_range(0, 3) == 0)
              idx = $urandom_range(0, 1) ? 0
                                         : $urandom_range(MAX_ORDER + 1, (1 << IDX_W) - 1);
            else
              idx = $urandom_range(1, MAX_ORDER);
            send_item(load_item(idx, pick_coef()));
            if (idx >= 1 && idx <= MAX_ORDER) phase_items++;
          end
          // the first band of a phase sometimes continues the old history,
          // so the new order applies mid-band
          if (i == 0) start = !(first_band && $urandom_range(0, 1));
          else        start = ($urandom_range(0, 39) == 0);
          send_item(sample_item(pick_sample(), start));
          phase_items++;
        end
        first_band = 1'b0;
      end
    end

    // Wind down: wait for the outstanding outputs, bounded, then let the
    // pipe settle so a stray extra output would still be caught.
    item_if.valid <= 1'b0;
    tx_calm = 1'b1;
    for (int w = 0; w < 5000 && sb.pending() != 0; w++) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected outputs never arrived", sb.pending()));

    $display("Filtered %0d samples after %0d tap loads across %0d order settings;",
             sb.samples, sb.loads, order_writes);
    $display("%0d outputs clipped at the rails, %0d mismatches seen.",
             sb.clipped, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lpef_pkg.sv
rtl/lpef_if.sv
rtl/lpef_tap_cell.sv
rtl/lpef_adder_tree.sv
rtl/lpc_prediction_error_filter.sv
test/lpc_prediction_error_filter_test.sv
